[design/pattern_occurrence_counter_macros.svh]
// Assertion helpers for the pattern occurrence counter tally module.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef PATTERN_OCCURRENCE_COUNTER_MACROS_SVH
`define PATTERN_OCCURRENCE_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define POC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define POC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/poc_pkg.sv]
`timescale 1ns / 1ps

package poc_pkg;

    // Fixed field and register widths.
    localparam int BYTE_W      = 8;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;
    localparam int LEN_W       = 5;
    localparam int OUT_COUNT_W = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    // Parameter defaults.
    localparam int PATTERN_MAX_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    typedef logic [BYTE_W-1:0] byte_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // Per-transaction control handed from the window to the tally stage.
    typedef struct packed {
        logic accept;
        logic last;
        logic window_hit;
    } step_t;

endpackage

[design/poc_cell.sv]
`timescale 1ns / 1ps

module poc_cell
    import poc_pkg::*;
(
    input  logic  clk,
    input  logic  shift_en,
    input  logic  clear,
    input  byte_t byte_in,
    input  byte_t pat_byte,
    input  logic  active,
    output byte_t byte_out,
    output logic  match
);

    byte_t byte_reg;
    byte_t byte_next;

    // The compare looks at the byte this slot takes on the current shift.
    assign match = !active || (byte_in == pat_byte);

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = '0;
        end
        else if (shift_en)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

[design/poc_tally.sv]
`timescale 1ns / 1ps
`include "pattern_occurrence_counter_macros.svh"

module poc_tally
    import poc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  step_t                  step,
    input  logic [LEN_W-1:0]       eff_len,
    input  logic                   out_ready,
    output logic                   in_ready,
    output logic                   out_valid,
    output logic                   occurrence_found,
    output logic [OUT_COUNT_W-1:0] occurrences_so_far,
    output logic                   text_done
);

    localparam int SEEN_W = $clog2(PATTERN_MAX + 1);

    logic [SEEN_W-1:0]      bytes_seen_reg;
    logic [SEEN_W-1:0]      bytes_seen_next;
    logic [SEEN_W-1:0]      seen_inc;
    logic [COUNT_WIDTH-1:0] match_total_reg;
    logic [COUNT_WIDTH-1:0] match_total_next;
    logic [COUNT_WIDTH-1:0] total_inc;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic                   found_next;
    logic                   done_reg;
    logic [OUT_COUNT_W-1:0] count_out_reg;
    logic [OUT_COUNT_W-1:0] count_out_next;

    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        seen_inc = bytes_seen_reg;
        if (bytes_seen_reg != SEEN_W'(PATTERN_MAX))
        begin
            seen_inc = bytes_seen_reg + SEEN_W'(1);
        end
        found_next = step.window_hit && (LEN_W'(seen_inc) >= eff_len);
        total_inc = match_total_reg;
        if (found_next && (match_total_reg != '1))
        begin
            total_inc = match_total_reg + COUNT_WIDTH'(1);
        end
    end

    generate
        if (COUNT_WIDTH > OUT_COUNT_W)
        begin : g_wide
            assign count_out_next = (total_inc > COUNT_WIDTH'({OUT_COUNT_W{1'b1}})) ?
                                    '1 : total_inc[OUT_COUNT_W-1:0];
        end
        else
        begin : g_narrow
            assign count_out_next = OUT_COUNT_W'(total_inc);
        end
    endgenerate

    always_comb
    begin
        bytes_seen_next  = bytes_seen_reg;
        match_total_next = match_total_reg;
        out_valid_next   = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step.accept)
        begin
            out_valid_next = 1'b1;
            if (step.last)
            begin
                bytes_seen_next  = '0;
                match_total_next = '0;
            end
            else
            begin
                bytes_seen_next  = seen_inc;
                match_total_next = total_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg  <= '0;
            match_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bytes_seen_reg  <= bytes_seen_next;
            match_total_reg <= match_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.accept)
        begin
            found_reg     <= found_next;
            done_reg      <= step.last;
            count_out_reg <= count_out_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign occurrence_found   = found_reg;
    assign occurrences_so_far = count_out_reg;
    assign text_done          = done_reg;

    `POC_ASSERT_NOW(a_found_counted, out_valid_reg && found_reg, count_out_reg != '0, "occurrence flagged with zero count")
    `POC_ASSERT_NEXT(a_last_clears, step.accept && step.last, (bytes_seen_reg == '0) && (match_total_reg == '0), "text end did not clear counters")
    `POC_ASSERT_NEXT(a_count_monotonic, step.accept && !step.last, match_total_reg >= $past(match_total_reg), "match count decreased within a text")
    `POC_ASSERT_NOW(a_seen_bounded, 1'b1, bytes_seen_reg <= SEEN_W'(PATTERN_MAX), "byte count beyond window depth")
    `POC_ASSERT_NOW(a_no_accept_on_stall, out_valid_reg && !out_ready, !step.accept, "transaction taken while result stalled")

endmodule

[design/pattern_occurrence_counter.sv]
// Pattern occurrence counter.
// Write the pattern through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data): index 0 holds pattern bytes 0 to 7, index 1 bytes 8 to
// 15, index 2 the pattern length. The channel is always ready; other indexes
// are ignored. Configure only while no transaction is in flight.
// Text bytes arrive on the input channel (in_valid, in_ready), one per
// transaction, with end_of_text on the final byte. Every input transaction
// yields one output transaction in the next cycle, carrying the match flag, the
// running saturating count and a copy of end_of_text.
// Throughput is one byte per cycle: a row of cells shifts the window and
// compares every active slot with its pattern byte in the cycle the byte is
// taken, and a single output register holds the result.
// When the receiver stalls, the output register holds its transaction and
// in_ready drops until it is taken. Reset clears the pattern, sets the
// length to one and clears the counters, but not the window; the byte flagged
// end_of_text clears the window and counters after its result.
`timescale 1ns / 1ps

module pattern_occurrence_counter
    import poc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      text_byte,
    input  logic                   end_of_text,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   occurrence_found,
    output logic [OUT_COUNT_W-1:0] occurrences_so_far,
    output logic                   text_done
);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_low_next;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [CFG_DATA_W-1:0] pat_high_next;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [LEN_W-1:0]      pat_len_next;
    logic [LEN_W-1:0]      eff_len;
    byte_t                 pattern [PAT_BYTES];
    byte_t                 chain   [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] match_vec;
    logic                  accept;
    step_t                 step;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes fall to the default arm.
    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        pat_len_next  = pat_len_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:    pat_low_next  = cfg_data;
                REG_PATTERN_HIGH:   pat_high_next = cfg_data;
                REG_PATTERN_LENGTH: pat_len_next  = cfg_data[LEN_W-1:0];
                default:            pat_len_next  = pat_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
        end
        else
        begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            pat_len_reg  <= pat_len_next;
        end
    end

    // A length of zero acts as one; lengths beyond the window are clipped.
    always_comb
    begin
        eff_len = pat_len_reg;
        if (pat_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (pat_len_reg > LEN_W'(PATTERN_MAX))
        begin
            eff_len = LEN_W'(PATTERN_MAX);
        end
    end

    // Unpack the sixteen pattern bytes, byte 0 in the low bits.
    generate
        for (genvar j = 0; j < PAT_BYTES / 2; j++)
        begin : g_unpack
            assign pattern[j]                 = pat_low_reg[j*BYTE_W +: BYTE_W];
            assign pattern[j + PAT_BYTES / 2] = pat_high_reg[j*BYTE_W +: BYTE_W];
        end
    endgenerate

    assign accept = in_valid && in_ready;

    // Window chain: slot 0 takes the new byte, each slot passes its byte on.
    // Slot k lines up with pattern byte (length - 1 - k).
    assign chain[0] = text_byte;

    generate
        for (genvar k = 0; k < PATTERN_MAX; k++)
        begin : g_cells
            logic [LEN_W-1:0] pat_idx;
            logic             active;

            assign active  = LEN_W'(k) < eff_len;
            assign pat_idx = eff_len - LEN_W'(k + 1);

            poc_cell u_cell (
                .clk      (clk),
                .shift_en (accept),
                .clear    (accept && end_of_text),
                .byte_in  (chain[k]),
                .pat_byte (pattern[pat_idx[PAT_IDX_W-1:0]]),
                .active   (active),
                .byte_out (chain[k+1]),
                .match    (match_vec[k])
            );
        end
    endgenerate

    assign step.accept     = accept;
    assign step.last       = end_of_text;
    assign step.window_hit = &match_vec;

    poc_tally #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tally (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .eff_len            (eff_len),
        .out_ready          (out_ready),
        .in_ready           (in_ready),
        .out_valid          (out_valid),
        .occurrence_found   (occurrence_found),
        .occurrences_so_far (occurrences_so_far),
        .text_done          (text_done)
    );

endmodule
